>>> hdl/ppws_pkg.sv
`timescale 1ns / 1ps

package ppws_pkg;

    // Largest row or column count that the profile memory holds.
    localparam int MAX_EXTENT = 256;
    localparam int ADDR_W     = $clog2(MAX_EXTENT);

    // Widths fixed by the register and stream fields.
    localparam int DIM_W      = 9;
    localparam int CNT_W      = 9;
    localparam int PIX_W      = 8;
    localparam int START_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CNT_W-1:0] BIN_MAX = {CNT_W{1'b1}};

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_THRESHOLD = 3'd4;

    // Reset values of the registers.
    localparam logic [DIM_W-1:0] RESET_IMAGE_WIDTH     = 9'd256;
    localparam logic [DIM_W-1:0] RESET_IMAGE_HEIGHT    = 9'd256;
    localparam logic [DIM_W-1:0] RESET_WINDOW_SIZE     = 9'd16;
    localparam logic [PIX_W-1:0] RESET_PIXEL_THRESHOLD = 8'd100;

    typedef struct packed {
        logic             axis_mode;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [DIM_W-1:0] window_size;
        logic [PIX_W-1:0] pixel_threshold;
    } ppws_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic pix_accept;
        logic walk_init;
        logic scan_issue;
        logic walk_bound;
        logic walk_cmp;
        logic emit;
    } ppws_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic win_fits;
        logic bound_branch;
        logic out_free;
    } ppws_status_t;

    // A zero dimension acts as one, an oversized one as the memory depth.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_EXTENT))
        begin
            r = DIM_W'(MAX_EXTENT);
        end
        return r;
    endfunction

endpackage

>>> hdl/ppws_bin_ram.sv
`timescale 1ns / 1ps

// Profile bin store: one write port and two registered read ports.
module ppws_bin_ram
(
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [ppws_pkg::ADDR_W-1:0]          wr_addr,
    input  logic [ppws_pkg::CNT_W-1:0]           wr_data,
    input  logic [ppws_pkg::ADDR_W-1:0]          rd_addr_a,
    input  logic [ppws_pkg::ADDR_W-1:0]          rd_addr_b,
    output logic [ppws_pkg::CNT_W-1:0]           rd_data_a,
    output logic [ppws_pkg::CNT_W-1:0]           rd_data_b
);

    logic [ppws_pkg::CNT_W-1:0] mem [ppws_pkg::MAX_EXTENT];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

>>> hdl/ppws_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: pixel intake, bound scan, window walk and result hand-off.
module ppws_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_last,
    output logic                   in_ready,
    input  ppws_pkg::ppws_status_t status,
    output ppws_pkg::ppws_cmd_t    cmd
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DRAIN,
        ST_SCAN,
        ST_SCAN_END,
        ST_WALK_CHECK,
        ST_WALK_CMP,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.pix_accept = 1'b1;
                    if (in_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                // The last pixel's bin update lands during this cycle.
                cmd.walk_init = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_WALK_CHECK;
            end
            ST_WALK_CHECK:
            begin
                if (status.win_fits)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.bound_branch)
                begin
                    cmd.walk_bound = 1'b1;
                end
                else
                begin
                    state_next = ST_WALK_CMP;
                end
            end
            ST_WALK_CMP:
            begin
                cmd.walk_cmp = 1'b1;
                state_next   = ST_WALK_CHECK;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/ppws_datapath.sv
`timescale 1ns / 1ps

// Raster position, bin accumulation, zero-bin bounds and window registers.
module ppws_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ppws_pkg::ppws_cfg_t                 cfg,
    input  ppws_pkg::ppws_cmd_t                 cmd,
    output ppws_pkg::ppws_status_t              status,
    input  logic [ppws_pkg::PIX_W-1:0]          pixel,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ppws_pkg::START_W-1:0]        out_start
);

    localparam int AW = ppws_pkg::ADDR_W;
    localparam int DW = ppws_pkg::DIM_W;
    localparam int CW = ppws_pkg::CNT_W;

    // Profile geometry from the current registers.
    logic [DW-1:0] dim_w;
    logic [DW-1:0] dim_h;
    logic [DW-1:0] len;
    logic [AW-1:0] mid;
    logic [AW-1:0] len_m1;
    logic [DW-1:0] target;

    assign dim_w  = ppws_pkg::clamp_dim(cfg.image_width);
    assign dim_h  = ppws_pkg::clamp_dim(cfg.image_height);
    assign len    = cfg.axis_mode ? dim_w : dim_h;
    assign mid    = AW'(len >> 1);
    assign len_m1 = AW'(len - DW'(1));
    assign target = (cfg.window_size == '0) ? DW'(1) : cfg.window_size;

    // Raster position.
    logic [AW-1:0] col_reg;
    logic [AW-1:0] row_reg;
    logic [AW-1:0] bin_addr;
    logic [DW-1:0] col_new;
    logic [DW-1:0] row_new;

    always_comb
    begin
        logic [DW-1:0] c0;
        logic [DW-1:0] r0;
        c0 = {1'b0, col_reg};
        r0 = {1'b0, row_reg};
        if (c0 >= dim_w)
        begin
            c0 = '0;
            r0 = r0 + DW'(1);
        end
        if (r0 >= dim_h)
        begin
            r0 = '0;
        end
        bin_addr = cfg.axis_mode ? c0[AW-1:0] : r0[AW-1:0];
        col_new  = c0 + DW'(1);
        row_new  = r0;
        if (col_new >= dim_w)
        begin
            col_new = '0;
            row_new = r0 + DW'(1);
            if (row_new >= dim_h)
            begin
                row_new = '0;
            end
        end
    end

    // Bin store and its valid bits.
    logic [MAX_LANES-1:0] unused_dummy;
    localparam int MAX_LANES = ppws_pkg::MAX_EXTENT;
    logic [MAX_LANES-1:0] bin_valid_reg;
    logic [AW-1:0]        rd_addr_a;
    logic [AW-1:0]        rd_addr_b;
    logic [CW-1:0]        rd_data_a;
    logic [CW-1:0]        rd_data_b;
    logic                 vld_a_reg;
    logic                 vld_b_reg;
    logic [CW-1:0]        bin_a;
    logic [CW-1:0]        bin_b;
    logic                 wr_en;
    logic [CW-1:0]        wr_data;

    assign unused_dummy = bin_valid_reg;

    // Scan and walk registers.
    logic [AW-1:0] scan_s_reg;
    logic          chk_valid_reg;
    logic [AW-1:0] chk_s_reg;
    logic [AW-1:0] zbl_reg;
    logic [AW-1:0] zbh_reg;
    logic          low_found_reg;
    logic          high_found_reg;
    logic [AW-1:0] b_reg;
    logic [AW-1:0] e_reg;

    assign rd_addr_a = cmd.pix_accept ? bin_addr : (cmd.scan_issue ? scan_s_reg : b_reg);
    assign rd_addr_b = cmd.scan_issue ? AW'(len_m1 - scan_s_reg) : e_reg;

    assign bin_a = vld_a_reg ? rd_data_a : '0;
    assign bin_b = vld_b_reg ? rd_data_b : '0;

    // Update stage of the read-modify-write, with forwarding of the last write.
    logic          s2_valid_reg;
    logic [AW-1:0] s2_addr_reg;
    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [CW-1:0] fwd_data_reg;
    logic [CW-1:0] cur_count;

    assign cur_count = (fwd_valid_reg && (fwd_addr_reg == s2_addr_reg)) ? fwd_data_reg : bin_a;
    assign wr_en     = s2_valid_reg && (cur_count != ppws_pkg::BIN_MAX);
    assign wr_data   = cur_count + CW'(1);

    ppws_bin_ram u_bin_ram
    (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (s2_addr_reg),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Scan check and walk arithmetic.
    logic [AW-1:0]       hi_idx;
    logic [DW-1:0]       win_len;
    logic signed [AW+1:0] lead;
    logic signed [AW+1:0] tail;

    assign hi_idx  = AW'(len_m1 - chk_s_reg);
    assign win_len = {1'b0, e_reg} - {1'b0, b_reg} + DW'(1);
    assign lead    = $signed({2'b00, zbl_reg}) - $signed({2'b00, b_reg});
    assign tail    = $signed({2'b00, e_reg}) - $signed({2'b00, zbh_reg});

    logic out_valid_reg;
    logic [ppws_pkg::START_W-1:0] out_start_reg;

    assign status.scan_last    = (scan_s_reg == mid);
    assign status.win_fits     = (win_len <= target);
    assign status.bound_branch = (zbl_reg > b_reg) || (zbh_reg < e_reg);
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_start = out_start_reg;

    // Read data and the update stage's operand registers carry no reset.
    always_ff @(posedge clk)
    begin
        vld_a_reg    <= bin_valid_reg[rd_addr_a];
        vld_b_reg    <= bin_valid_reg[rd_addr_b];
        s2_addr_reg  <= bin_addr;
        fwd_addr_reg <= s2_addr_reg;
        fwd_data_reg <= wr_data;
        chk_s_reg    <= scan_s_reg;
        if (cmd.emit)
        begin
            out_start_reg <= ppws_pkg::START_W'(b_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            bin_valid_reg  <= '0;
            s2_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            scan_s_reg     <= '0;
            chk_valid_reg  <= 1'b0;
            zbl_reg        <= '0;
            zbh_reg        <= '0;
            low_found_reg  <= 1'b0;
            high_found_reg <= 1'b0;
            b_reg          <= '0;
            e_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= cmd.pix_accept && (pixel <= cfg.pixel_threshold);
            fwd_valid_reg <= wr_en;
            chk_valid_reg <= cmd.scan_issue;

            if (cmd.pix_accept)
            begin
                col_reg <= col_new[AW-1:0];
                row_reg <= row_new[AW-1:0];
            end

            if (wr_en)
            begin
                bin_valid_reg[s2_addr_reg] <= 1'b1;
            end

            if (cmd.walk_init)
            begin
                scan_s_reg     <= '0;
                zbl_reg        <= mid;
                zbh_reg        <= mid;
                low_found_reg  <= 1'b0;
                high_found_reg <= 1'b0;
                b_reg          <= '0;
                e_reg          <= len_m1;
            end

            if (cmd.scan_issue)
            begin
                scan_s_reg <= scan_s_reg + AW'(1);
            end

            if (chk_valid_reg)
            begin
                if (!low_found_reg && (bin_a == '0))
                begin
                    zbl_reg       <= chk_s_reg;
                    low_found_reg <= 1'b1;
                end
                if (!high_found_reg && (hi_idx > mid) && (bin_b == '0))
                begin
                    zbh_reg        <= hi_idx;
                    high_found_reg <= 1'b1;
                end
            end

            if (cmd.walk_bound)
            begin
                if (lead > tail)
                begin
                    b_reg <= b_reg + AW'(1);
                end
                else
                begin
                    e_reg <= e_reg - AW'(1);
                end
            end

            if (cmd.walk_cmp)
            begin
                if (bin_b < bin_a)
                begin
                    e_reg <= e_reg - AW'(1);
                end
                else
                begin
                    b_reg <= b_reg + AW'(1);
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                bin_valid_reg <= '0;
                col_reg       <= '0;
                row_reg       <= '0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> hdl/projection_profile_window_select.sv
`timescale 1ns / 1ps
// Order: a pixel's bin is read on a registered RAM port and written back by the update stage;
// the result follows the last pixel after the bound scan over half the profile length and the
// window walk, which moves one end of the window in per step until it fits the window size.
// Throughput: one pixel request per cycle within a component; the bin read-modify-write
// forwards the previous update, so repeated hits on one bin do not stall.
// Reset: asynchronous and active low; registers with a reset return to their reset values and all
// bins read as zero through per-bin valid flags, so no clearing pass is needed.
module projection_profile_window_select
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Pixel stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] pixel
    input  logic                                s_axis_tlast,   // last_pixel
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,   // [7:0] window_start
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ppws_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppws_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // The register file. Writes are always taken; indexes past the list are
    // ignored. The user must write registers only while the block is idle, so
    // the datapath sees stable values across a component; the block itself does not enforce this.
    ppws_pkg::ppws_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis_mode       <= 1'b0;
            cfg_reg.image_width     <= ppws_pkg::RESET_IMAGE_WIDTH;
            cfg_reg.image_height    <= ppws_pkg::RESET_IMAGE_HEIGHT;
            cfg_reg.window_size     <= ppws_pkg::RESET_WINDOW_SIZE;
            cfg_reg.pixel_threshold <= ppws_pkg::RESET_PIXEL_THRESHOLD;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ppws_pkg::CFG_AXIS_MODE:
                begin
                    cfg_reg.axis_mode <= cfg_data[0];
                end
                ppws_pkg::CFG_IMAGE_WIDTH:
                begin
                    cfg_reg.image_width <= cfg_data;
                end
                ppws_pkg::CFG_IMAGE_HEIGHT:
                begin
                    cfg_reg.image_height <= cfg_data;
                end
                ppws_pkg::CFG_WINDOW_SIZE:
                begin
                    cfg_reg.window_size <= cfg_data;
                end
                ppws_pkg::CFG_PIXEL_THRESHOLD:
                begin
                    cfg_reg.pixel_threshold <= cfg_data[ppws_pkg::PIX_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // The controller sequences a component: it takes pixel requests while
    // idle, then on the last pixel runs the zero-bin scan from both ends of
    // the profile at once, walks the window in towards the target size and
    // hands the start to the output register, which the datapath holds
    // until the downstream side takes it.
    ppws_pkg::ppws_cmd_t    cmd;
    ppws_pkg::ppws_status_t status;

    ppws_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ppws_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .status    (status),
        .pixel     (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_start (m_axis_tdata)
    );

endmodule

>>> hdl/ppws_checker.sv
`timescale 1ns / 1ps

// Port-level checks, attached to the top level by the bind below.
module ppws_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [7:0]                      s_axis_tdata,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [7:0]                      m_axis_tdata,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [ppws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [ppws_pkg::CFG_DATA_W-1:0] cfg_data
);

    // A waiting result holds still until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

    // The last pixel of a component closes the pixel side for the scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("pixel side reopened before the bound scan");

    // A new result only appears at the end of the search, when pixels are held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised while pixels were being taken");

    // Configuration requests are never held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("configuration request stalled");

endmodule

bind projection_profile_window_select ppws_checker u_ppws_checker (.*);
